// ===== rtl/core/dmct_pkg.sv =====
// Shared types and constants for the direct-mapped cache timing block.
// Depends on nothing; used by every file in rtl/core.
package dmct_pkg;

    localparam logic [2:0] KIND_TICK      = 3'd0;
    localparam logic [2:0] KIND_LOAD      = 3'd1;
    localparam logic [2:0] KIND_STORE     = 3'd2;
    localparam logic [2:0] KIND_ACC_STORE = 3'd3;
    localparam logic [2:0] KIND_ATOMIC    = 3'd4;

    localparam logic [3:0] OUT_HIT      = 4'd0;
    localparam logic [3:0] OUT_MISS     = 4'd1;
    localparam logic [3:0] OUT_FAULT    = 4'd2;
    localparam logic [3:0] OUT_CONFLICT = 4'd3;
    localparam logic [3:0] OUT_BW_STALL = 4'd4;
    localparam logic [3:0] OUT_Q_FULL   = 4'd5;
    localparam logic [3:0] OUT_STORE    = 4'd6;
    localparam logic [3:0] OUT_ATOMIC   = 4'd7;
    localparam logic [3:0] OUT_TICK     = 4'd8;

    localparam logic [2:0] CFG_HIT_LAT   = 3'd0;
    localparam logic [2:0] CFG_MEM_LAT   = 3'd1;
    localparam logic [2:0] CFG_STORE_LAT = 3'd2;
    localparam logic [2:0] CFG_MEM_WORDS = 3'd3;
    localparam logic [2:0] CFG_DRAIN     = 3'd4;
    localparam logic [2:0] CFG_OUT_LIMIT = 3'd5;
    localparam logic [2:0] CFG_BYPASS    = 3'd6;

    localparam int          LAT_W   = 11;
    localparam logic [10:0] LAT_MAX = 11'd2047;
    localparam int          OUTS_W  = 17;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_EXEC,
        ST_TSCAN,
        ST_TDRAIN
    } state_t;

    typedef struct packed {
        logic push;
        logic lookup;
        logic scan;
        logic pop;
    } fq_ctrl_t;

    typedef struct packed {
        logic        full;
        logic        hit;
        logic        any_due;
        logic [31:0] hit_due;
    } fq_stat_t;

    function automatic logic [10:0] sat_lat(input logic [11:0] v);
        sat_lat = (v > {1'b0, LAT_MAX}) ? LAT_MAX : v[10:0];
    endfunction

endpackage

// ===== rtl/core/direct_mapped_cache_timing.sv =====
// Top level of the direct-mapped banked cache timing block.
// Depends on dmct_pkg and dmct_fill_queue.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+-----------------------------------
//  input    | s_valid / s_ready        | s_kind, s_address
//  result   | m_valid / m_ready        | m_accepted, m_outcome, m_latency
//  config   | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// Steps: an access is captured, then the tag RAM is read with the queue lookup,
// then it is decided and written back; a tick is captured, scans the queue,
// then commits the due fills oldest first, each commit being one tag RAM write.
// Reset: a clearing pass writes every tag RAM line invalid; no item is
// taken until it ends. Config writes are taken at any time.
// Stalls: one item is worked on at a time; a held result blocks only the
// final step of the next item.
module direct_mapped_cache_timing #(
    parameter int INDEX_LINES = 4096,
    parameter int LINE_BITS   = 3,
    parameter int BANK_COUNT  = 8,
    parameter int FILL_DEPTH  = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_kind,
    input  logic [31:0] s_address,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_accepted,
    output logic [3:0]  m_outcome,
    output logic [10:0] m_latency,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    // INDEX_LINES and BANK_COUNT are powers of two
    localparam int IDX_W  = $clog2(INDEX_LINES);
    localparam int TAG_W  = 32 - LINE_BITS - IDX_W;
    localparam int BANK_W = (BANK_COUNT > 1) ? $clog2(BANK_COUNT) : 1;
    localparam int OW     = dmct_pkg::OUTS_W;

    dmct_pkg::state_t state_reg, state_next;

    // configuration
    logic [7:0]  hit_lat_reg;
    logic [9:0]  mem_lat_reg;
    logic [9:0]  store_lat_reg;
    logic [31:0] mem_words_reg;
    logic [7:0]  drain_reg;
    logic [15:0] out_limit_reg;
    logic        bypass_reg;

    // item and block state
    logic [2:0]            kind_reg;
    logic [31:0]           addr_reg;
    logic [BANK_COUNT-1:0] bank_busy_reg, bank_busy_next;
    logic [OW-1:0]         outs_reg, outs_next;
    logic [31:0]           cycle_reg, cycle_next;
    logic [IDX_W-1:0]      clr_cnt_reg;

    // result register
    logic        m_valid_reg, m_valid_next;
    logic        m_acc_reg, m_acc_next;
    logic [3:0]  m_outcome_reg, m_outcome_next;
    logic [10:0] m_lat_reg, m_lat_next;

    // tag RAM: {valid, tag}
    logic [TAG_W:0]   tag_mem [INDEX_LINES];
    logic [TAG_W:0]   mem_rdata_reg;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [TAG_W:0]   mem_wdata;

    dmct_pkg::fq_ctrl_t fq_ctrl;
    dmct_pkg::fq_stat_t fq_stat;
    logic [IDX_W-1:0]   head_idx;
    logic [TAG_W-1:0]   head_tag;

    logic [31:0]       line_w;
    logic [IDX_W-1:0]  idx_w;
    logic [TAG_W-1:0]  tag_w;
    logic [BANK_W-1:0] bank_w;
    logic              out_free, finish;
    logic [31:0]       rem;
    logic [31:0]       push_due;
    logic [OW-1:0]     fill_words;

    assign line_w     = addr_reg >> LINE_BITS;
    assign idx_w      = line_w[IDX_W-1:0];
    assign tag_w      = TAG_W'(line_w >> IDX_W);
    assign bank_w     = BANK_W'(addr_reg % BANK_COUNT);
    assign fill_words = OW'(1) << LINE_BITS;
    assign push_due   = cycle_reg + 32'(hit_lat_reg) + 32'(mem_lat_reg);

    assign s_ready   = (state_reg == dmct_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;

    assign m_valid    = m_valid_reg;
    assign m_accepted = m_acc_reg;
    assign m_outcome  = m_outcome_reg;
    assign m_latency  = m_lat_reg;

    // read at the captured address: data is ready in the decide step
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            tag_mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= tag_mem[idx_w];
    end

    dmct_fill_queue #(
        .FILL_DEPTH (FILL_DEPTH),
        .IDX_W      (IDX_W),
        .TAG_W      (TAG_W)
    ) u_fq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (fq_ctrl),
        .push_idx (idx_w),
        .push_tag (tag_w),
        .push_due (push_due),
        .lk_idx   (idx_w),
        .lk_tag   (tag_w),
        .cycle    (cycle_reg),
        .stat     (fq_stat),
        .head_idx (head_idx),
        .head_tag (head_tag)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            dmct_pkg::ST_CLEAR: begin
                if (clr_cnt_reg == IDX_W'(INDEX_LINES - 1)) begin
                    state_next = dmct_pkg::ST_IDLE;
                end
            end
            dmct_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = (s_kind == dmct_pkg::KIND_TICK) ? dmct_pkg::ST_TSCAN
                                                                 : dmct_pkg::ST_LOOKUP;
                end
            end
            dmct_pkg::ST_LOOKUP: state_next = dmct_pkg::ST_EXEC;
            dmct_pkg::ST_EXEC: begin
                if (out_free) begin
                    state_next = dmct_pkg::ST_IDLE;
                end
            end
            dmct_pkg::ST_TSCAN: state_next = dmct_pkg::ST_TDRAIN;
            dmct_pkg::ST_TDRAIN: begin
                if (!fq_stat.any_due && out_free) begin
                    state_next = dmct_pkg::ST_IDLE;
                end
            end
            default: state_next = dmct_pkg::ST_CLEAR;
        endcase
    end

    // datapath and outputs
    always_comb begin
        fq_ctrl        = '0;
        mem_we         = 1'b0;
        mem_waddr      = idx_w;
        mem_wdata      = '0;
        bank_busy_next = bank_busy_reg;
        outs_next      = outs_reg;
        cycle_next     = cycle_reg;
        finish         = 1'b0;
        m_acc_next     = m_acc_reg;
        m_outcome_next = m_outcome_reg;
        m_lat_next     = m_lat_reg;
        rem            = fq_stat.hit_due - cycle_reg;
        if (rem[31]) begin
            rem = '0;
        end

        case (state_reg)
            dmct_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
            end
            dmct_pkg::ST_LOOKUP: fq_ctrl.lookup = 1'b1;
            dmct_pkg::ST_TSCAN:  fq_ctrl.scan = 1'b1;
            dmct_pkg::ST_TDRAIN: begin
                if (fq_stat.any_due) begin
                    // commit the oldest due fill
                    mem_we      = 1'b1;
                    mem_waddr   = head_idx;
                    mem_wdata   = {1'b1, head_tag};
                    fq_ctrl.pop = 1'b1;
                end else if (out_free) begin
                    finish         = 1'b1;
                    outs_next      = (outs_reg > OW'(drain_reg)) ? outs_reg - OW'(drain_reg) : '0;
                    cycle_next     = cycle_reg + 32'd1;
                    bank_busy_next = '0;
                    m_acc_next     = 1'b1;
                    m_outcome_next = dmct_pkg::OUT_TICK;
                    m_lat_next     = '0;
                end
            end
            dmct_pkg::ST_EXEC: begin
                if (out_free) begin
                    finish     = 1'b1;
                    m_acc_next = 1'b1;
                    m_lat_next = '0;
                    if (kind_reg > dmct_pkg::KIND_ATOMIC
                        || (kind_reg == dmct_pkg::KIND_LOAD && addr_reg >= mem_words_reg)) begin
                        m_outcome_next = dmct_pkg::OUT_FAULT;
                    end else if (bank_busy_reg[bank_w] && !bypass_reg) begin
                        m_acc_next     = 1'b0;
                        m_outcome_next = dmct_pkg::OUT_CONFLICT;
                    end else if (kind_reg == dmct_pkg::KIND_LOAD) begin
                        if (!bypass_reg && mem_rdata_reg[TAG_W] && mem_rdata_reg[TAG_W-1:0] == tag_w) begin
                            bank_busy_next[bank_w] = 1'b1;
                            m_outcome_next = dmct_pkg::OUT_HIT;
                            m_lat_next     = 11'(hit_lat_reg);
                        end else if (fq_stat.hit) begin
                            bank_busy_next[bank_w] = 1'b1;
                            m_outcome_next = (rem != '0) ? dmct_pkg::OUT_MISS : dmct_pkg::OUT_HIT;
                            m_lat_next     = dmct_pkg::sat_lat(12'(hit_lat_reg)
                                + 12'(dmct_pkg::sat_lat((rem > 32'd4095) ? 12'd4095 : rem[11:0])));
                        end else if (outs_reg >= OW'(out_limit_reg)) begin
                            m_acc_next     = 1'b0;
                            m_outcome_next = dmct_pkg::OUT_BW_STALL;
                        end else if (fq_stat.full) begin
                            m_acc_next     = 1'b0;
                            m_outcome_next = dmct_pkg::OUT_Q_FULL;
                        end else begin
                            fq_ctrl.push = 1'b1;
                            outs_next    = outs_reg + fill_words;
                            bank_busy_next[bank_w] = 1'b1;
                            m_outcome_next = dmct_pkg::OUT_MISS;
                            m_lat_next     = 11'(hit_lat_reg) + 11'(mem_lat_reg);
                        end
                    end else if (kind_reg == dmct_pkg::KIND_ATOMIC) begin
                        // an equal tag drops the valid bit
                        if (mem_rdata_reg[TAG_W-1:0] == tag_w) begin
                            mem_we    = 1'b1;
                            mem_wdata = {1'b0, tag_w};
                        end
                        bank_busy_next[bank_w] = 1'b1;
                        m_outcome_next = dmct_pkg::OUT_ATOMIC;
                        m_lat_next     = 11'(hit_lat_reg) + 11'(mem_lat_reg);
                    end else if (outs_reg >= OW'(out_limit_reg)) begin
                        m_acc_next     = 1'b0;
                        m_outcome_next = dmct_pkg::OUT_BW_STALL;
                    end else begin
                        outs_next = outs_reg + fill_words;
                        bank_busy_next[bank_w] = 1'b1;
                        m_outcome_next = dmct_pkg::OUT_STORE;
                        m_lat_next     = 11'(hit_lat_reg) + 11'(store_lat_reg);
                    end
                end
            end
            default: begin
            end
        endcase

        if (finish) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= dmct_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            bank_busy_reg <= '0;
            outs_reg      <= '0;
            cycle_reg     <= '0;
            m_valid_reg   <= 1'b0;
            hit_lat_reg   <= 8'd1;
            mem_lat_reg   <= 10'd100;
            store_lat_reg <= 10'd0;
            mem_words_reg <= 32'hFFFF_FFFF;
            drain_reg     <= 8'd8;
            out_limit_reg <= 16'd256;
            bypass_reg    <= 1'b0;
        end else begin
            state_reg     <= state_next;
            bank_busy_reg <= bank_busy_next;
            outs_reg      <= outs_next;
            cycle_reg     <= cycle_next;
            m_valid_reg   <= m_valid_next;
            if (state_reg == dmct_pkg::ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cfg_valid) begin
                case (cfg_index)
                    dmct_pkg::CFG_HIT_LAT:   hit_lat_reg   <= cfg_data[7:0];
                    dmct_pkg::CFG_MEM_LAT:   mem_lat_reg   <= cfg_data[9:0];
                    dmct_pkg::CFG_STORE_LAT: store_lat_reg <= cfg_data[9:0];
                    dmct_pkg::CFG_MEM_WORDS: mem_words_reg <= cfg_data;
                    dmct_pkg::CFG_DRAIN:     drain_reg     <= cfg_data[7:0];
                    dmct_pkg::CFG_OUT_LIMIT: out_limit_reg <= cfg_data[15:0];
                    dmct_pkg::CFG_BYPASS:    bypass_reg    <= cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // item capture and result payload need no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            kind_reg <= s_kind;
            addr_reg <= s_address;
        end
        m_acc_reg     <= m_acc_next;
        m_outcome_reg <= m_outcome_next;
        m_lat_reg     <= m_lat_next;
    end

endmodule

// ===== rtl/core/dmct_fill_queue.sv =====
// Bounded line-fill queue kept in arrival order: lookup, due scan, ordered pop.
// Depends on dmct_pkg.
module dmct_fill_queue #(
    parameter int FILL_DEPTH = 16,
    parameter int IDX_W      = 12,
    parameter int TAG_W      = 17
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  dmct_pkg::fq_ctrl_t ctrl,
    input  logic [IDX_W-1:0]   push_idx,
    input  logic [TAG_W-1:0]   push_tag,
    input  logic [31:0]        push_due,
    input  logic [IDX_W-1:0]   lk_idx,
    input  logic [TAG_W-1:0]   lk_tag,
    input  logic [31:0]        cycle,
    output dmct_pkg::fq_stat_t stat,
    output logic [IDX_W-1:0]   head_idx,
    output logic [TAG_W-1:0]   head_tag
);
    localparam int PTR_W = (FILL_DEPTH > 1) ? $clog2(FILL_DEPTH) : 1;
    localparam int CNT_W = $clog2(FILL_DEPTH + 1);

    logic [IDX_W-1:0]      idx_q [FILL_DEPTH];
    logic [TAG_W-1:0]      tag_q [FILL_DEPTH];
    logic [31:0]           due_q [FILL_DEPTH];
    logic [CNT_W-1:0]      count_reg;
    logic [FILL_DEPTH-1:0] due_vec_reg;
    logic                  hit_reg;
    logic [31:0]           hit_due_reg;

    logic                  lk_hit;
    logic [31:0]           lk_due;
    logic [PTR_W-1:0]      head_k;
    logic [31:0]           diff [FILL_DEPTH];

    // first match in arrival order
    always_comb begin
        lk_hit = 1'b0;
        lk_due = '0;
        for (int k = FILL_DEPTH - 1; k >= 0; k--) begin
            if ((CNT_W'(k) < count_reg) && idx_q[k] == lk_idx && tag_q[k] == lk_tag) begin
                lk_hit = 1'b1;
                lk_due = due_q[k];
            end
        end
    end

    always_comb begin
        head_k = '0;
        for (int k = FILL_DEPTH - 1; k >= 0; k--) begin
            if (due_vec_reg[k]) begin
                head_k = PTR_W'(k);
            end
        end
    end

    always_comb begin
        for (int k = 0; k < FILL_DEPTH; k++) begin
            diff[k] = cycle - due_q[k];
        end
    end

    assign head_idx     = idx_q[head_k];
    assign head_tag     = tag_q[head_k];
    assign stat.full    = (count_reg >= CNT_W'(FILL_DEPTH));
    assign stat.hit     = hit_reg;
    assign stat.hit_due = hit_due_reg;
    assign stat.any_due = |due_vec_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            due_vec_reg <= '0;
            hit_reg     <= 1'b0;
        end else begin
            if (ctrl.lookup) begin
                hit_reg <= lk_hit;
            end
            if (ctrl.push) begin
                count_reg <= count_reg + 1'b1;
            end else if (ctrl.pop) begin
                count_reg <= count_reg - 1'b1;
            end
            if (ctrl.scan) begin
                for (int k = 0; k < FILL_DEPTH; k++) begin
                    due_vec_reg[k] <= (CNT_W'(k) < count_reg) && !diff[k][31];
                end
            end else if (ctrl.pop) begin
                for (int k = 0; k < FILL_DEPTH; k++) begin
                    if (PTR_W'(k) >= head_k) begin
                        due_vec_reg[k] <= (k < FILL_DEPTH - 1) ? due_vec_reg[(k + 1) % FILL_DEPTH]
                                                               : 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.lookup) begin
            hit_due_reg <= lk_due;
        end
        if (ctrl.push) begin
            idx_q[count_reg[PTR_W-1:0]] <= push_idx;
            tag_q[count_reg[PTR_W-1:0]] <= push_tag;
            due_q[count_reg[PTR_W-1:0]] <= push_due;
        end else if (ctrl.pop) begin
            // close the gap left by the popped entry
            for (int k = 0; k < FILL_DEPTH - 1; k++) begin
                if (PTR_W'(k) >= head_k) begin
                    idx_q[k] <= idx_q[k + 1];
                    tag_q[k] <= tag_q[k + 1];
                    due_q[k] <= due_q[k + 1];
                end
            end
        end
    end

endmodule

// ===== rtl/core/dmct_checker.sv =====
// Port-level checks for the cache timing block, bound to its top level.
// Depends on dmct_pkg and direct_mapped_cache_timing.
module dmct_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_accepted,
    input logic [3:0]  m_outcome,
    input logic [10:0] m_latency
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_outcome) && $stable(m_latency))
        else $error("result changed while stalled");

    a_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_outcome == dmct_pkg::OUT_TICK |-> m_accepted && m_latency == 11'd0)
        else $error("bad tick result");

    a_reject: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_accepted |-> m_latency == 11'd0
            && (m_outcome == dmct_pkg::OUT_CONFLICT || m_outcome == dmct_pkg::OUT_BW_STALL
                || m_outcome == dmct_pkg::OUT_Q_FULL))
        else $error("bad rejected result");

    a_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_outcome == dmct_pkg::OUT_FAULT |-> m_accepted && m_latency == 11'd0)
        else $error("bad fault result");

endmodule

bind direct_mapped_cache_timing dmct_checker u_dmct_checker (.*);
